// ===== rtl/fcip_pkg.sv =====
`timescale 1ns / 1ps
// Package for the framed CSV integer parser: byte classes, queue word and
// parser phase types, character codes. No dependencies.
package fcip_pkg;

  // Character codes
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_TAB   = 8'h09;  // first of TAB, LF, VT, FF, CR
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Frame shape
  localparam int FIELD_COUNT = 5;
  localparam int FNUM_W      = 3;

  // Queue between front and back; depth is a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    K_START,
    K_END,
    K_COMMA,
    K_BLANK,
    K_MINUS,
    K_PLUS,
    K_DIGIT,
    K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } link_t;

  typedef enum logic [1:0] {
    PH_BLANK,
    PH_DIGITS,
    PH_DONE
  } phase_t;

endpackage

// ===== rtl/fcip_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts received bytes and classifies them into queue words.
// Depends on fcip_pkg.
module fcip_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] rx_byte
  output fcip_pkg::link_t front_out,
  input  logic          front_ready
);
  import fcip_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r, item_nxt;
  item_t cls;

  // Classify one byte
  always_comb begin
    cls.digit = in_tdata[3:0];
    if (in_tdata == CH_LT) begin
      cls.kind = K_START;
    end else if (in_tdata == CH_GT) begin
      cls.kind = K_END;
    end else if (in_tdata == CH_COMMA) begin
      cls.kind = K_COMMA;
    end else if (in_tdata == CH_SPACE || (in_tdata >= CH_TAB && in_tdata <= CH_CR)) begin
      cls.kind = K_BLANK;
    end else if (in_tdata == CH_MINUS) begin
      cls.kind = K_MINUS;
    end else if (in_tdata == CH_PLUS) begin
      cls.kind = K_PLUS;
    end else if (in_tdata >= CH_ZERO && in_tdata <= CH_NINE) begin
      cls.kind = K_DIGIT;
    end else begin
      cls.kind = K_OTHER;
    end
  end

  assign in_tready = !vld_r || front_ready;

  always_comb begin
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (in_tready) begin
      vld_nxt  = in_tvalid;
      item_nxt = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    item_r <= item_nxt;
  end

  assign front_out.valid = vld_r;
  assign front_out.item  = item_r;

endmodule

// ===== rtl/fcip_queue.sv =====
`timescale 1ns / 1ps
// Short word queue between the front end and the parser back end.
// Depends on fcip_pkg.
module fcip_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  fcip_pkg::link_t wr_link,
  output logic            wr_ready,
  output fcip_pkg::link_t rd_link,
  input  logic            rd_ready
);
  import fcip_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign push     = wr_link.valid && wr_ready;
  assign pop      = rd_link.valid && rd_ready;

  assign rd_link.valid = count_r != '0;
  assign rd_link.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_link.item;
    end
  end

endmodule

// ===== rtl/fcip_back.sv =====
`timescale 1ns / 1ps
// Back end: frame and field parser with the result output register.
// Depends on fcip_pkg.
module fcip_back #(
  parameter int VALUE_BITS = 16,
  parameter int TDATA_W    = 80
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fcip_pkg::link_t    q_link,
  output logic               q_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata
);
  import fcip_pkg::*;

  localparam int ACC_W = VALUE_BITS + 4;
  localparam int PACK_W = FIELD_COUNT * VALUE_BITS;
  localparam logic [VALUE_BITS-1:0] LIM = VALUE_BITS'(1) << (VALUE_BITS - 1);
  localparam logic [VALUE_BITS-1:0] MAX_POS = LIM - 1'b1;

  logic                  in_frame_r, in_frame_nxt;
  logic [FNUM_W-1:0]     field_num_r, field_num_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  neg_r, neg_nxt;
  phase_t                phase_r, phase_nxt;
  logic                  last_comma_r, last_comma_nxt;
  logic                  nonempty_r, nonempty_nxt;
  logic [VALUE_BITS-1:0] fields_r [FIELD_COUNT];
  logic [VALUE_BITS-1:0] fields_nxt [FIELD_COUNT];
  logic                  out_valid_r, out_valid_nxt;
  logic [PACK_W-1:0]     out_data_r, out_data_nxt;

  logic                  fire, do_close, result;
  item_t                 it;
  logic [ACC_W-1:0]      acc_ext, acc_sum;
  logic [VALUE_BITS-1:0] acc_sat, close_val;

  assign it      = q_link.item;
  // Only a frame end can make a result, so only it waits on the output slot
  assign q_ready = (it.kind != K_END) || !out_valid_r || out_tready;
  assign fire    = q_link.valid && q_ready;

  // Multiply by ten and add the digit, then clip at the limit
  assign acc_ext = ACC_W'(acc_r);
  assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(it.digit);
  assign acc_sat = (acc_sum > ACC_W'(LIM)) ? LIM : acc_sum[VALUE_BITS-1:0];

  assign close_val = neg_r ? (~acc_r + 1'b1) : ((acc_r == LIM) ? MAX_POS : acc_r);

  // Parser next state
  always_comb begin
    in_frame_nxt   = in_frame_r;
    field_num_nxt  = field_num_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    phase_nxt      = phase_r;
    last_comma_nxt = last_comma_r;
    nonempty_nxt   = nonempty_r;
    fields_nxt     = fields_r;
    do_close       = 1'b0;
    if (fire) begin
      if (it.kind == K_START) begin
        in_frame_nxt   = 1'b1;
        field_num_nxt  = '0;
        last_comma_nxt = 1'b0;
        nonempty_nxt   = 1'b0;
        acc_nxt        = '0;
        neg_nxt        = 1'b0;
        phase_nxt      = PH_BLANK;
      end else if (in_frame_r) begin
        if (it.kind == K_END) begin
          in_frame_nxt = 1'b0;
          do_close     = nonempty_r && !last_comma_r;
        end else begin
          nonempty_nxt = 1'b1;
          if (it.kind == K_COMMA) begin
            last_comma_nxt = 1'b1;
            do_close       = 1'b1;
          end else begin
            last_comma_nxt = 1'b0;
            if (field_num_r < FNUM_W'(FIELD_COUNT)) begin
              case (phase_r)
                PH_BLANK: begin
                  case (it.kind)
                    K_BLANK: begin
                    end
                    K_MINUS: begin
                      phase_nxt = PH_DIGITS;
                      neg_nxt   = 1'b1;
                    end
                    K_PLUS: begin
                      phase_nxt = PH_DIGITS;
                    end
                    K_DIGIT: begin
                      phase_nxt = PH_DIGITS;
                      acc_nxt   = acc_sat;
                    end
                    default: begin
                      phase_nxt = PH_DONE;
                    end
                  endcase
                end
                PH_DIGITS: begin
                  if (it.kind == K_DIGIT) begin
                    acc_nxt = acc_sat;
                  end else begin
                    phase_nxt = PH_DONE;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
    end
    // Close the open field: store it if there is room, then clear the number
    if (do_close) begin
      if (field_num_r < FNUM_W'(FIELD_COUNT)) begin
        fields_nxt[field_num_r] = close_val;
        field_num_nxt           = field_num_r + 1'b1;
      end
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      phase_nxt = PH_BLANK;
    end
  end

  assign result = fire && in_frame_r && (it.kind == K_END) &&
                  (field_num_nxt >= FNUM_W'(FIELD_COUNT));

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (result) begin
      out_valid_nxt = 1'b1;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        out_data_nxt[i*VALUE_BITS +: VALUE_BITS] = fields_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      field_num_r  <= '0;
      acc_r        <= '0;
      neg_r        <= 1'b0;
      phase_r      <= PH_BLANK;
      last_comma_r <= 1'b0;
      nonempty_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      field_num_r  <= field_num_nxt;
      acc_r        <= acc_nxt;
      neg_r        <= neg_nxt;
      phase_r      <= phase_nxt;
      last_comma_r <= last_comma_nxt;
      nonempty_r   <= nonempty_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    fields_r   <= fields_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);

  a_fnum_range: assert property (@(posedge clk) disable iff (!rst_n)
    field_num_r <= FNUM_W'(FIELD_COUNT))
    else $error("field count past five");

  a_acc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= LIM)
    else $error("magnitude above saturation limit");

  a_blank_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BLANK) |-> (acc_r == '0 && !neg_r))
    else $error("number not cleared while skipping blanks");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && it.kind == K_END) |=> !in_frame_r)
    else $error("frame still open after frame end");

  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    result |-> (it.kind == K_END && in_frame_r))
    else $error("result without frame end");

endmodule

// ===== rtl/framed_csv_integer_parser.sv =====
`timescale 1ns / 1ps
// Framed CSV integer parser: one received byte per word in, one word of five
// saturated signed values out for each complete frame <v1,v2,v3,v4,v5>.
// Throughput: one byte per cycle; only a '>' byte waits, while the last word is unread.
// A '>' byte passes the front register and the queue; its result is held in the back end's output register.
// Reset (rst_n low, synchronous): no frame open, queue empty, no result pending.
// Depends on fcip_pkg, fcip_front, fcip_queue, fcip_back.
module framed_csv_integer_parser #(
  parameter int VALUE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // Received byte stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  // Parsed frames
  output logic       out_tvalid,
  input  logic       out_tready,
  // from bit 0: value_one, value_two, value_three, value_four, mode_value,
  // each VALUE_BITS wide, then zero fill to a whole byte
  output logic [((fcip_pkg::FIELD_COUNT * VALUE_BITS + 7) / 8) * 8 - 1:0] out_tdata
);
  import fcip_pkg::*;

  localparam int TDATA_W = ((FIELD_COUNT * VALUE_BITS + 7) / 8) * 8;

  // Front end: register and classify each byte
  link_t front_link;
  logic  front_ready;
  // Back end side of the queue
  link_t back_link;
  logic  back_ready;

  fcip_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .front_out   (front_link),
    .front_ready (front_ready)
  );

  // Decouple the two halves so a stalled output never stalls byte intake at once
  fcip_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_link  (front_link),
    .wr_ready (front_ready),
    .rd_link  (back_link),
    .rd_ready (back_ready)
  );

  // Back end: frame tracking, field parsing, result register
  fcip_back #(
    .VALUE_BITS (VALUE_BITS),
    .TDATA_W    (TDATA_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_link     (back_link),
    .q_ready    (back_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
